// ----- hdl/egsc_pkg.sv -----
// Shared widths, variant codes and the divider request type for the GCD step counter.
// No dependencies; every other file of the block refers to it by scoped names.
package egsc_pkg;

   localparam int OPERAND_WIDTH = 32;
   localparam int COUNT_WIDTH   = $clog2(OPERAND_WIDTH);
   localparam int STEP_WIDTH    = 6;
   localparam int VARIANT_WIDTH = 2;

   localparam logic [STEP_WIDTH-1:0] STEP_MAX = {STEP_WIDTH{1'b1}};

   localparam logic [VARIANT_WIDTH-1:0] VAR_SWAP     = 2'd0;
   localparam logic [VARIANT_WIDTH-1:0] VAR_PLAIN    = 2'd1;
   localparam logic [VARIANT_WIDTH-1:0] VAR_ROTATE   = 2'd2;
   localparam logic [VARIANT_WIDTH-1:0] VAR_RESERVED = 2'd3;
   localparam logic [VARIANT_WIDTH-1:0] VARIANT_RESET = VAR_PLAIN;

   typedef struct packed {
      logic                     start;
      logic [OPERAND_WIDTH-1:0] dividend;
      logic [OPERAND_WIDTH-1:0] divisor;
   } div_req_type;

endpackage

// ----- hdl/egsc_req_if.sv -----
// Request channel: one beat carries the two operands.
// Depends on egsc_pkg for the operand width.
interface egsc_req_if;
   logic                               valid;
   logic                               ready;
   logic [egsc_pkg::OPERAND_WIDTH-1:0] first_operand;
   logic [egsc_pkg::OPERAND_WIDTH-1:0] second_operand;

   modport source (output valid, output first_operand, output second_operand, input ready);
   modport sink   (input valid, input first_operand, input second_operand, output ready);
endinterface

// ----- hdl/egsc_rsp_if.sv -----
// Response channel: one beat carries the divisor, the pass count and the error flag.
// Depends on egsc_pkg for the field widths.
interface egsc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [egsc_pkg::OPERAND_WIDTH-1:0] gcd_value;
   logic [egsc_pkg::STEP_WIDTH-1:0]    step_count;
   logic                               operand_error;

   modport source (output valid, output gcd_value, output step_count, output operand_error,
                   input ready);
   modport sink   (input valid, input gcd_value, input step_count, input operand_error,
                   output ready);
endinterface

// ----- hdl/egsc_rem_unit.sv -----
// Shared radix-2 restoring remainder unit: one quotient bit per cycle.
// Depends on egsc_pkg for the operand width and the request type.
module egsc_rem_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  egsc_pkg::div_req_type              req,
   output logic                               done,
   output logic [egsc_pkg::OPERAND_WIDTH-1:0] remainder
);

   localparam int W = egsc_pkg::OPERAND_WIDTH;

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [egsc_pkg::COUNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [W-1:0]                       rem_ff, rem_in;
   logic [W-1:0]                       dvd_ff, dvd_in;
   logic [W-1:0]                       dsr_ff, dsr_in;
   logic [W:0]                         partial;
   logic [W:0]                         diff;

   assign partial = {rem_ff, dvd_ff[W-1]};
   assign diff    = partial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = egsc_pkg::COUNT_WIDTH'(W - 1);
         rem_in  = '0;
         dvd_in  = req.dividend;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         // restore when the trial subtraction borrows
         rem_in = diff[W] ? partial[W-1:0] : diff[W-1:0];
         dvd_in = {dvd_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ----- hdl/euclid_gcd_step_count.sv -----
// Top level of the GCD step counter: sequencer, variant register and response register.
// Depends on egsc_pkg, egsc_req_if, egsc_rsp_if and egsc_rem_unit.
//
// Takes one pair of operands at a time and returns their greatest common divisor with the
// number of loop passes that the selected variant counts. Every remainder runs on one shared
// restoring divider, one after another, down to a zero remainder (at most about 47 remainders
// for 32-bit operands); a zero operand or the reserved variant skips the divider and returns
// zero. The request side is ready only while no item is under work; a finished result waits
// in the response register, and the next request is taken meanwhile. Write the variant only
// while the block is idle.
module euclid_gcd_step_count (
   input  logic                                   clock,
   input  logic                                   reset,
   egsc_req_if.sink                               req,
   egsc_rsp_if.source                             rsp,
   input  logic                                   csr_write_enable,
   input  logic [egsc_pkg::VARIANT_WIDTH-1:0]     csr_write_data
);

   localparam int W = egsc_pkg::OPERAND_WIDTH;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIVIDE = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]                             state_ff, state_in;
   logic [egsc_pkg::VARIANT_WIDTH-1:0]     variant_ff, variant_in;
   logic [W-1:0]                           b_ff, b_in;
   logic [egsc_pkg::STEP_WIDTH-1:0]        steps_ff, steps_in;
   logic                                   err_ff, err_in;
   logic [1:0]                             phase_ff, phase_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]                           gcd_out_ff, gcd_out_in;
   logic [egsc_pkg::STEP_WIDTH-1:0]        steps_out_ff, steps_out_in;
   logic                                   err_out_ff, err_out_in;

   egsc_pkg::div_req_type                  div_req;
   logic                                   div_done;
   logic [W-1:0]                           div_rem;
   logic                                   req_beat;
   logic                                   zero_op;
   logic                                   counts;
   logic                                   rsp_free;

   egsc_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .req       (div_req),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign req.ready = (state_ff == ST_IDLE);
   assign req_beat  = req.valid && req.ready;
   assign zero_op   = (req.first_operand == '0) || (req.second_operand == '0);
   assign rsp_free  = !rsp_valid_ff || rsp.ready;

   // pass counted on every remainder, or on the second and then every third one when rotating
   assign counts = (variant_ff != egsc_pkg::VAR_ROTATE) || (phase_ff == 2'd2);

   always_comb begin
      variant_in       = csr_write_enable ? csr_write_data : variant_ff;
      state_in         = state_ff;
      b_in             = b_ff;
      steps_in         = steps_ff;
      err_in           = err_ff;
      phase_in         = phase_ff;
      div_req.start    = 1'b0;
      div_req.dividend = req.first_operand;
      div_req.divisor  = req.second_operand;
      rsp_valid_in     = rsp_valid_ff && !rsp.ready;
      gcd_out_in       = gcd_out_ff;
      steps_out_in     = steps_out_ff;
      err_out_in       = err_out_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               steps_in = '0;
               phase_in = 2'd1;
               err_in   = zero_op;
               if (zero_op || variant_ff == egsc_pkg::VAR_RESERVED) begin
                  b_in     = '0;
                  state_in = ST_FINISH;
               end else begin
                  b_in          = req.second_operand;
                  div_req.start = 1'b1;
                  state_in      = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               if (counts && steps_ff != egsc_pkg::STEP_MAX) begin
                  steps_in = steps_ff + 1'b1;
               end
               phase_in = (phase_ff == 2'd2) ? 2'd0 : phase_ff + 2'd1;
               if (div_rem == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  // advance: divisor becomes dividend, remainder becomes divisor
                  div_req.start    = 1'b1;
                  div_req.dividend = b_ff;
                  div_req.divisor  = div_rem;
                  b_in             = div_rem;
               end
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               gcd_out_in   = b_ff;
               steps_out_in = steps_ff;
               err_out_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         variant_ff   <= egsc_pkg::VARIANT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         variant_ff   <= variant_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      b_ff         <= b_in;
      steps_ff     <= steps_in;
      err_ff       <= err_in;
      phase_ff     <= phase_in;
      gcd_out_ff   <= gcd_out_in;
      steps_out_ff <= steps_out_in;
      err_out_ff   <= err_out_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.gcd_value     = gcd_out_ff;
   assign rsp.step_count    = steps_out_ff;
   assign rsp.operand_error = err_out_ff;

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req.ready)
      else $error("request taken while an item is under work");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVIDE)
      else $error("remainder finished outside the divide state");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.operand_error |-> rsp.gcd_value == '0 && rsp.step_count == '0)
      else $error("error beat carries a divisor or a pass count");

   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && rsp_free |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("finished result not moved to the response register");

endmodule
